FILE: hw/rtl/eas_pkg.sv
// Shared widths, register codes, reset values, states and saturation helper for the speed filter.
package eas_pkg;

  localparam int ANGLE_BITS_DEFAULT = 13;
  localparam int MAX_DECIMATION     = 16;

  localparam int THR_W      = 12;
  localparam int DEC_W      = 5;
  localparam int COEF_W     = 16;
  localparam int OFF_W      = 13;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int SUM_W   = 18;
  localparam int SPEED_W = 16;
  localparam int PROD_W  = SPEED_W + COEF_W + 1;
  localparam int ACC_W   = PROD_W + 1;

  localparam int ALPHA_ONE   = 32768;
  localparam int ALPHA_SHIFT = 15;
  localparam int SCALE_SHIFT = 8;
  localparam int SPEED_MAX   = 32767;
  localparam int SPEED_MIN   = -32768;

  localparam logic [THR_W-1:0]  WRAP_THRESHOLD_RST = THR_W'(100);
  localparam logic [DEC_W-1:0]  DECIMATION_RST     = DEC_W'(5);
  localparam logic [COEF_W-1:0] FILTER_ALPHA_RST   = COEF_W'(31130);
  localparam logic [COEF_W-1:0] SPEED_SCALE_RST    = COEF_W'(2250);
  localparam logic [OFF_W-1:0]  ANGLE_OFFSET_RST   = OFF_W'(6864);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRAP_THRESHOLD = 3'd0,
    CFG_DECIMATION     = 3'd1,
    CFG_FILTER_ALPHA   = 3'd2,
    CFG_SPEED_SCALE    = 3'd3,
    CFG_ANGLE_OFFSET   = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEW_GO,
    ST_NEW_RUN,
    ST_OLD_GO,
    ST_OLD_RUN,
    ST_FILT,
    ST_SCALE_GO,
    ST_SCALE_RUN,
    ST_RESULT
  } state_e;

  function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(SPEED_MAX);
    lo = ACC_W'(SPEED_MIN);
    if (v > hi) begin
      return SPEED_W'(SPEED_MAX);
    end else if (v < lo) begin
      return SPEED_W'(SPEED_MIN);
    end
    return v[SPEED_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/eas_serial_mul.sv
// Bit-serial shift-add multiplier: signed operand times unsigned operand, one bit per cycle.
module eas_serial_mul import eas_pkg::*; #(
  parameter int A_W = SPEED_W,
  parameter int B_W = COEF_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [A_W-1:0]   a_i,
  input  logic [B_W-1:0]          b_i,
  output logic                    done_o,
  output logic signed [A_W+B_W:0] prod_o
);

  localparam int H_W   = A_W + 2;
  localparam int CNT_W = $clog2(B_W + 1);

  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic signed [A_W-1:0] a_q;
  logic signed [H_W-1:0] hi_q, hi_d;
  logic [B_W-1:0]        lo_q, lo_d;
  logic signed [H_W-1:0] addend;
  logic signed [H_W-1:0] sum;
  logic [H_W+B_W-1:0]    full;

  always_comb begin
    addend = lo_q[0] ? H_W'(a_q) : '0;
    sum    = hi_q + addend;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(B_W);
      hi_d   = '0;
      lo_d   = b_i;
    end else if (busy_q) begin
      hi_d  = sum >>> 1;
      lo_d  = {sum[0], lo_q[B_W-1:1]};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    if (start_i) begin
      a_q <= a_i;
    end
  end

  assign done_o = busy_q && (cnt_q == CNT_W'(1));
  assign full   = {hi_q, lo_q};
  assign prod_o = $signed(full[A_W+B_W:0]);

endmodule

FILE: hw/rtl/encoder_angle_to_speed_filter.sv
// Top level of the encoder angle to speed estimator with first-order low-pass filter.
//
// One encoder angle enters per beat on the input channel (in_valid_i, in_stall_o,
// raw_angle_i). Each angle produces exactly one result beat on the output channel
// (out_valid_o, out_stall_i) carrying the held raw speed, the filtered speed, the
// speed in degrees per second and the recentred angle.
// The shared bit-serial multiplier makes three passes per angle: the new-speed
// weight, the filter memory weight and the output scale. The input stalls from
// acceptance until the result has moved into the output register. A finished
// result waits there while the receiver stalls; the next angle may be taken
// meanwhile, but its result is held back until the register is free.
// Configuration writes go straight into the registers and are meant for idle periods.
// Reset is asynchronous and active low: it restores the register defaults, clears
// the previous angle, running sum, sample count, held speed and filter memory, and
// empties the output register.
module encoder_angle_to_speed_filter import eas_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ANGLE_BITS-1:0]        raw_angle_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [SPEED_W-1:0]    raw_speed_o,
  output logic signed [SPEED_W-1:0]    filtered_speed_o,
  output logic signed [SPEED_W-1:0]    speed_deg_s_o,
  output logic signed [ANGLE_BITS-1:0] centered_angle_o
);

  localparam int DW    = ((ANGLE_BITS > THR_W) ? ANGLE_BITS : THR_W) + 2;
  localparam int EXT_W = ((SUM_W > DW) ? SUM_W : DW) + 1;
  localparam int CEN_W = ANGLE_BITS + 1;

  localparam logic signed [DW-1:0]    Span      = DW'(1 << ANGLE_BITS);
  localparam logic signed [EXT_W-1:0] SumHi     = EXT_W'((1 << (SUM_W - 1)) - 1);
  localparam logic signed [EXT_W-1:0] SumLo     = EXT_W'(-(1 << (SUM_W - 1)));
  localparam logic signed [CEN_W-1:0] FoldLimit = CEN_W'((1 << (ANGLE_BITS - 1)) - 1);
  localparam logic signed [CEN_W-1:0] FoldStep  = CEN_W'((1 << ANGLE_BITS) - 1);

  state_e state_q, state_d;

  logic [THR_W-1:0]  thr_q;
  logic [DEC_W-1:0]  dec_q;
  logic [COEF_W-1:0] alpha_q;
  logic [COEF_W-1:0] scale_q;
  logic [OFF_W-1:0]  off_q;

  logic [ANGLE_BITS-1:0]     prev_q;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [DEC_W-1:0]          cnt_q, cnt_d;
  logic signed [SPEED_W-1:0] held_q, held_d;
  logic signed [SPEED_W-1:0] mem_q;
  logic signed [PROD_W-1:0]  acc_q;
  logic signed [ANGLE_BITS-1:0] cen_q;
  logic signed [ANGLE_BITS-1:0] cen_d;

  logic                      out_valid_q;
  logic                      out_load;
  logic signed [SPEED_W-1:0] raw_speed_q;
  logic signed [SPEED_W-1:0] filtered_speed_q;
  logic signed [SPEED_W-1:0] speed_deg_s_q;
  logic signed [ANGLE_BITS-1:0] centered_angle_q;

  logic                      in_accept;
  logic                      mul_start;
  logic                      mul_done;
  logic signed [SPEED_W-1:0] mul_a;
  logic [COEF_W-1:0]         mul_b;
  logic signed [PROD_W-1:0]  mul_prod;

  logic [COEF_W-1:0]         alpha_eff;
  logic [COEF_W-1:0]         beta;
  logic signed [DW-1:0]      diff;
  logic signed [DW-1:0]      thr_s;
  logic signed [DW-1:0]      step;
  logic signed [EXT_W-1:0]   sum_ext;
  logic signed [SUM_W-1:0]   sum_sat;
  logic [DEC_W-1:0]          cnt_inc;
  logic [DEC_W-1:0]          dec_eff;
  logic                      latch;
  logic signed [CEN_W-1:0]   cen_w;
  logic signed [ACC_W-1:0]   filt_tot;
  logic signed [ACC_W-1:0]   filt_quo;
  logic signed [SPEED_W-1:0] filt;
  logic signed [ACC_W-1:0]   deg_quo;
  logic signed [SPEED_W-1:0] deg;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_load  = (state_q == ST_RESULT) && (!out_valid_q || !out_stall_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_NEW_GO;
      ST_NEW_GO:    state_d = ST_NEW_RUN;
      ST_NEW_RUN:   if (mul_done) state_d = ST_OLD_GO;
      ST_OLD_GO:    state_d = ST_OLD_RUN;
      ST_OLD_RUN:   if (mul_done) state_d = ST_FILT;
      ST_FILT:      state_d = ST_SCALE_GO;
      ST_SCALE_GO:  state_d = ST_SCALE_RUN;
      ST_SCALE_RUN: if (mul_done) state_d = ST_RESULT;
      ST_RESULT:    if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Controls decoded from the state.
  always_comb begin
    in_stall_o = 1'b1;
    mul_start  = 1'b0;
    mul_a      = held_q;
    mul_b      = alpha_eff;
    unique case (state_q)
      ST_IDLE:     in_stall_o = 1'b0;
      ST_NEW_GO:   mul_start = 1'b1;
      ST_OLD_GO: begin
        mul_start = 1'b1;
        mul_a     = mem_q;
        mul_b     = beta;
      end
      ST_SCALE_GO: begin
        mul_start = 1'b1;
        mul_a     = mem_q;
        mul_b     = scale_q;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    alpha_eff = (alpha_q > COEF_W'(ALPHA_ONE)) ? COEF_W'(ALPHA_ONE) : alpha_q;
    beta      = COEF_W'(ALPHA_ONE - int'(alpha_eff));

    diff  = $signed(DW'(raw_angle_i)) - $signed(DW'(prev_q));
    thr_s = $signed(DW'(thr_q));
    if (diff < thr_s && diff > -thr_s) begin
      step = diff;
    end else if (diff <= -thr_s) begin
      step = diff + Span;
    end else begin
      step = diff - Span;
    end

    sum_ext = EXT_W'(sum_q) + EXT_W'(step);
    if (sum_ext > SumHi) begin
      sum_sat = SumHi[SUM_W-1:0];
    end else if (sum_ext < SumLo) begin
      sum_sat = SumLo[SUM_W-1:0];
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end

    cnt_inc = cnt_q + DEC_W'(1);
    if (dec_q == '0) begin
      dec_eff = DEC_W'(1);
    end else if (32'(dec_q) > MAX_DECIMATION) begin
      dec_eff = DEC_W'(MAX_DECIMATION);
    end else begin
      dec_eff = dec_q;
    end
    latch  = (cnt_inc >= dec_eff);
    cnt_d  = latch ? '0 : cnt_inc;
    sum_d  = latch ? '0 : sum_sat;
    held_d = latch ? sat_speed(ACC_W'(sum_sat)) : held_q;

    cen_w = $signed(CEN_W'(raw_angle_i)) - $signed(CEN_W'(ANGLE_BITS'(off_q)));
    if (cen_w > FoldLimit) begin
      cen_w = cen_w - FoldStep;
    end
    if (cen_w < -FoldLimit) begin
      cen_w = cen_w + FoldStep;
    end
    cen_d = cen_w[ANGLE_BITS-1:0];

    filt_tot = ACC_W'(acc_q) + ACC_W'(mul_prod);
    filt_quo = filt_tot >>> ALPHA_SHIFT;
    if (filt_tot < 0 && filt_tot[ALPHA_SHIFT-1:0] != '0) begin
      filt_quo = filt_quo + ACC_W'(1);
    end
    filt = sat_speed(filt_quo);

    deg_quo = ACC_W'(mul_prod) >>> SCALE_SHIFT;
    if (mul_prod < 0 && mul_prod[SCALE_SHIFT-1:0] != '0) begin
      deg_quo = deg_quo + ACC_W'(1);
    end
    deg = sat_speed(deg_quo);
  end

  eas_serial_mul #(
    .A_W (SPEED_W),
    .B_W (COEF_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= WRAP_THRESHOLD_RST;
      dec_q   <= DECIMATION_RST;
      alpha_q <= FILTER_ALPHA_RST;
      scale_q <= SPEED_SCALE_RST;
      off_q   <= ANGLE_OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WRAP_THRESHOLD: thr_q   <= cfg_data_i[THR_W-1:0];
        CFG_DECIMATION:     dec_q   <= cfg_data_i[DEC_W-1:0];
        CFG_FILTER_ALPHA:   alpha_q <= cfg_data_i[COEF_W-1:0];
        CFG_SPEED_SCALE:    scale_q <= cfg_data_i[COEF_W-1:0];
        CFG_ANGLE_OFFSET:   off_q   <= cfg_data_i[OFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      held_q      <= '0;
      mem_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      if (in_accept) begin
        prev_q <= raw_angle_i;
        sum_q  <= sum_d;
        cnt_q  <= cnt_d;
        held_q <= held_d;
      end
      if (state_q == ST_FILT) begin
        mem_q <= filt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cen_q <= cen_d;
    end
    if (state_q == ST_OLD_GO) begin
      acc_q <= mul_prod;
    end
    if (out_load) begin
      raw_speed_q      <= held_q;
      filtered_speed_q <= mem_q;
      speed_deg_s_q    <= deg;
      centered_angle_q <= cen_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign raw_speed_o      = raw_speed_q;
  assign filtered_speed_o = filtered_speed_q;
  assign speed_deg_s_o    = speed_deg_s_q;
  assign centered_angle_o = centered_angle_q;

endmodule

FILE: hw/rtl/eas_checker.sv
// Port-level checks on the speed filter and the bind that attaches them to the top level.
module eas_checker import eas_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [SPEED_W-1:0]    raw_speed_o,
  input logic signed [SPEED_W-1:0]    filtered_speed_o,
  input logic signed [SPEED_W-1:0]    speed_deg_s_o,
  input logic signed [ANGLE_BITS-1:0] centered_angle_o
);

  localparam logic [ANGLE_BITS-1:0] AngleMin = {1'b1, {(ANGLE_BITS - 1){1'b0}}};

  // A stalled result beat keeps all of its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(raw_speed_o) &&
      $stable(filtered_speed_o) && $stable(speed_deg_s_o) && $stable(centered_angle_o))
    else $error("stalled result beat changed");

  // Once an angle is taken the block is busy with it in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again without a busy cycle");

  // A new result only appears while the block is still holding off the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

  // The recentred angle is folded into the symmetric range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> centered_angle_o != AngleMin)
    else $error("centred angle outside folded range");

endmodule

bind encoder_angle_to_speed_filter eas_checker #(
  .ANGLE_BITS (ANGLE_BITS)
) u_eas_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .raw_speed_o      (raw_speed_o),
  .filtered_speed_o (filtered_speed_o),
  .speed_deg_s_o    (speed_deg_s_o),
  .centered_angle_o (centered_angle_o)
);
